// File: rtl/core/lcdws_pkg.sv
package lcdws_pkg;

    localparam int WAIT_W = 14;
    localparam int STEP_W = 4;
    localparam int ENABLE_PULSE_US_DEF = 20;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam logic [7:0] CPU_RESET = 8'd16;

    localparam logic [2:0] ACT_INIT   = 3'd0;
    localparam logic [2:0] ACT_CMD    = 3'd1;
    localparam logic [2:0] ACT_DATA   = 3'd2;
    localparam logic [2:0] ACT_CLEAR  = 3'd3;
    localparam logic [2:0] ACT_HOME   = 3'd4;
    localparam logic [2:0] ACT_CURSOR = 3'd5;
    localparam logic [2:0] ACT_NUMBER = 3'd6;

    localparam logic [WAIT_W-1:0] CMD_WAIT_US  = 14'd42;
    localparam logic [WAIT_W-1:0] DATA_WAIT_US = 14'd46;
    localparam logic [WAIT_W-1:0] SLOW_WAIT_US = 14'd2042;

    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CMD_DDRAM = 8'h80;
    localparam logic [7:0] CMD_CLEAR = 8'h01;
    localparam logic [7:0] CMD_HOME  = 8'h02;

    localparam logic [STEP_W-1:0] INIT_LAST_STEP = 4'd8;
    localparam logic [STEP_W-1:0] NUM_LAST_STEP  = 4'd5;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  byte_value;
        logic [3:0]  column;
        logic [2:0]  row;
        logic [15:0] number;
    } t_in;

    typedef struct packed {
        logic              strobe_res;
        logic              reg_select;
        logic [3:0]        nibble;
        logic [WAIT_W-1:0] wait_us;
        logic              last;
    } t_out;

    typedef struct packed {
        logic              pair;
        logic              strobe;
        logic              rs;
        logic [7:0]        data;
        logic [WAIT_W-1:0] wait_us;
        logic              last;
    } t_op;

    typedef struct packed {
        logic has_word;
        logic has_room;
    } t_q_stat;

    function automatic t_op init_op(input logic [STEP_W-1:0] step);
        t_op op;
        op = '{pair: 1'b0, strobe: 1'b1, rs: 1'b0, data: 8'h03, wait_us: 14'd1000,
               last: 1'b0};
        case (step)
            4'd0: begin
                op.strobe  = 1'b0;
                op.data    = 8'h00;
                op.wait_us = 14'd15000;
            end
            4'd1: op.wait_us = 14'd5000;
            4'd2: op.wait_us = 14'd1000;
            4'd3: op.wait_us = 14'd1000;
            4'd4: begin
                op.data    = 8'h02;
                op.wait_us = 14'd5000;
            end
            4'd5: begin
                op.pair    = 1'b1;
                op.data    = 8'h28;
                op.wait_us = CMD_WAIT_US;
            end
            4'd6: begin
                op.pair    = 1'b1;
                op.data    = 8'h0C;
                op.wait_us = CMD_WAIT_US;
            end
            4'd7: begin
                op.pair    = 1'b1;
                op.data    = 8'h06;
                op.wait_us = CMD_WAIT_US;
            end
            default: begin
                op.pair    = 1'b1;
                op.data    = CMD_CLEAR;
                op.wait_us = SLOW_WAIT_US;
                op.last    = 1'b1;
            end
        endcase
        return op;
    endfunction

    function automatic logic [13:0] place_value(input logic [STEP_W-1:0] step);
        logic [13:0] p;
        case (step)
            4'd1:    p = 14'd10000;
            4'd2:    p = 14'd1000;
            4'd3:    p = 14'd100;
            4'd4:    p = 14'd10;
            default: p = 14'd1;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] row_base(input logic [2:0] row);
        logic [7:0] b;
        case (row)
            3'd1:    b = 8'h00;
            3'd2:    b = 8'h40;
            3'd3:    b = 8'h10;
            default: b = 8'h50;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/core/lcdws_front.sv
module lcdws_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  lcdws_pkg::t_in        i_in,
    input  lcdws_pkg::t_q_stat    i_q_stat,
    output logic                  o_push,
    output lcdws_pkg::t_op        o_op
);

    logic                              r_busy;
    logic                              n_busy;
    lcdws_pkg::t_in                    r_req;
    logic [lcdws_pkg::STEP_W-1:0]      r_step;
    logic [lcdws_pkg::STEP_W-1:0]      n_step;
    logic [15:0]                       r_val;
    logic                              r_seen;

    logic        accept;
    logic        in_row_ok;
    logic        in_has_ops;
    logic [7:0]  cursor_byte;
    logic [13:0] place;
    logic [16:0] mult [10];
    logic [3:0]  digit;
    logic [16:0] remain;
    logic [7:0]  digit_chr;

    assign in_row_ok = (i_in.row != 3'd0) && (i_in.row <= 3'd4);
    assign in_has_ops = (i_in.action <= lcdws_pkg::ACT_HOME)
                      || (i_in.action == lcdws_pkg::ACT_NUMBER)
                      || ((i_in.action == lcdws_pkg::ACT_CURSOR) && in_row_ok);

    assign cursor_byte = lcdws_pkg::CMD_DDRAM + lcdws_pkg::row_base(r_req.row)
                       + {4'd0, r_req.column};

    always_comb begin
        place = lcdws_pkg::place_value(r_step);
        digit = 4'd0;
        for (int j = 0; j < 10; j++) begin
            mult[j] = 17'(j) * {3'd0, place};
        end
        for (int j = 1; j < 10; j++) begin
            if ({1'b0, r_val} >= mult[j]) begin
                digit = 4'(j);
            end
        end
        remain = {1'b0, r_val} - mult[digit];
        if (!r_seen && (digit == 4'd0) && (r_step != lcdws_pkg::NUM_LAST_STEP)) begin
            digit_chr = lcdws_pkg::CHR_SPACE;
        end else begin
            digit_chr = lcdws_pkg::CHR_ZERO + {4'd0, digit};
        end
    end

    always_comb begin
        o_op = '{pair: 1'b1, strobe: 1'b1, rs: 1'b0, data: r_req.byte_value,
                 wait_us: lcdws_pkg::CMD_WAIT_US, last: 1'b1};
        case (r_req.action)
            lcdws_pkg::ACT_INIT: o_op = lcdws_pkg::init_op(r_step);
            lcdws_pkg::ACT_CMD: begin
            end
            lcdws_pkg::ACT_DATA: begin
                o_op.rs      = 1'b1;
                o_op.wait_us = lcdws_pkg::DATA_WAIT_US;
            end
            lcdws_pkg::ACT_CLEAR: begin
                o_op.data    = lcdws_pkg::CMD_CLEAR;
                o_op.wait_us = lcdws_pkg::SLOW_WAIT_US;
            end
            lcdws_pkg::ACT_HOME: begin
                o_op.data    = lcdws_pkg::CMD_HOME;
                o_op.wait_us = lcdws_pkg::SLOW_WAIT_US;
            end
            lcdws_pkg::ACT_CURSOR: o_op.data = cursor_byte;
            default: begin
                if (r_step == '0) begin
                    o_op.data = cursor_byte;
                    o_op.last = 1'b0;
                end else begin
                    o_op.rs      = 1'b1;
                    o_op.data    = digit_chr;
                    o_op.wait_us = lcdws_pkg::DATA_WAIT_US;
                    o_op.last    = (r_step == lcdws_pkg::NUM_LAST_STEP);
                end
            end
        endcase
    end

    assign o_push = r_busy && i_q_stat.has_room;
    assign o_in_ready = !r_busy || (o_push && o_op.last);
    assign accept = i_in_valid && o_in_ready;

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        if (accept) begin
            n_busy = in_has_ops;
            n_step = ((i_in.action == lcdws_pkg::ACT_NUMBER) && !in_row_ok) ? 4'd1 : 4'd0;
        end else if (o_push && o_op.last) begin
            n_busy = 1'b0;
        end else if (o_push) begin
            n_step = r_step + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req  <= i_in;
            r_val  <= i_in.number;
            r_seen <= 1'b0;
        end else if (o_push && (r_req.action == lcdws_pkg::ACT_NUMBER) && (r_step != '0)) begin
            r_val  <= remain[15:0];
            r_seen <= r_seen || (digit != 4'd0);
        end
    end

endmodule

// File: rtl/core/lcdws_fifo.sv
module lcdws_fifo #(
    parameter int DEPTH = lcdws_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  lcdws_pkg::t_op        i_op,
    input  logic                  i_pop,
    output lcdws_pkg::t_op        o_op,
    output lcdws_pkg::t_q_stat    o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    lcdws_pkg::t_op r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_stat.has_word = (r_cnt != '0);
    assign o_stat.has_room = (r_cnt != CW'(DEPTH));
    assign do_push = i_push && o_stat.has_room;
    assign do_pop  = i_pop && o_stat.has_word;
    assign o_op = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: rtl/core/lcdws_back.sv
module lcdws_back #(
    parameter int ENABLE_PULSE_US = lcdws_pkg::ENABLE_PULSE_US_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [7:0]            i_cpu,
    input  lcdws_pkg::t_q_stat    i_q_stat,
    input  lcdws_pkg::t_op        i_op,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output lcdws_pkg::t_out       o_out
);

    localparam int PW = $clog2(ENABLE_PULSE_US * 255 + 1);

    logic [PW-1:0]   r_pulse_cyc;
    logic [PW-1:0]   r_cnt;
    lcdws_pkg::t_op  r_op;
    logic            r_have;
    logic            r_half;
    logic            r_ovalid;
    lcdws_pkg::t_out r_out;
    lcdws_pkg::t_out xfer;
    logic            emit;

    always_comb begin
        xfer.strobe_res = r_op.strobe;
        xfer.reg_select = r_op.rs;
        xfer.nibble     = r_op.data[3:0];
        xfer.wait_us    = r_op.wait_us;
        xfer.last       = r_op.last;
        if (r_op.pair && !r_half) begin
            xfer.nibble  = r_op.data[7:4];
            xfer.wait_us = '0;
            xfer.last    = 1'b0;
        end
    end

    assign emit  = r_have && (r_cnt == '0) && (!r_ovalid || i_out_ready);
    assign o_pop = !r_have && i_q_stat.has_word;
    assign o_out_valid = r_ovalid;
    assign o_out = r_out;

    always_ff @(posedge i_clk) begin
        r_pulse_cyc <= PW'(ENABLE_PULSE_US) * PW'(i_cpu);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have   <= 1'b0;
            r_half   <= 1'b0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_have <= 1'b1;
                r_half <= 1'b0;
                r_cnt  <= i_op.strobe ? r_pulse_cyc : '0;
            end else if (emit) begin
                if (r_op.pair && !r_half) begin
                    r_half <= 1'b1;
                    r_cnt  <= r_pulse_cyc;
                end else begin
                    r_have <= 1'b0;
                end
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - PW'(1);
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op <= i_op;
        end
        if (emit) begin
            r_out <= xfer;
        end
    end

endmodule

// File: rtl/core/char_lcd_4bit_write_sequencer.sv
// Words of a request pass from the front end's request register through the queue and the
// back end's operation register to the output register; each strobed word first waits out the
// enable pulse time, set by ENABLE_PULSE_US and cycles_per_microsecond. A byte goes out as a
// high then a low nibble word. Requests are taken while earlier ones drain through the queue.
// Reset: synchronous, active low; clears control state and sets cycles_per_microsecond
// to 16.
module char_lcd_4bit_write_sequencer #(
    parameter int ENABLE_PULSE_US = lcdws_pkg::ENABLE_PULSE_US_DEF,
    parameter int QUEUE_DEPTH     = lcdws_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  lcdws_pkg::t_in   i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output lcdws_pkg::t_out  o_out,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_data
);

    logic [7:0]         r_cpu;
    logic               push;
    logic               pop;
    lcdws_pkg::t_op     front_op;
    lcdws_pkg::t_op     head_op;
    lcdws_pkg::t_q_stat q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpu <= lcdws_pkg::CPU_RESET;
        end else if (i_cfg_we) begin
            r_cpu <= i_cfg_data;
        end
    end

    lcdws_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_op       (front_op)
    );

    lcdws_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .i_pop   (pop),
        .o_op    (head_op),
        .o_stat  (q_stat)
    );

    lcdws_back #(
        .ENABLE_PULSE_US (ENABLE_PULSE_US)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cpu       (r_cpu),
        .i_q_stat    (q_stat),
        .i_op        (head_op),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> q_stat.has_room)
        else $error("op pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_stat.has_word)
        else $error("op popped from empty queue");

    a_wait_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.strobe_res) |->
            (o_out.nibble == 4'd0) && !o_out.reg_select && (o_out.wait_us == 14'd15000))
        else $error("malformed wait-only word");

    a_high_nibble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.wait_us == '0)) |-> (o_out.strobe_res && !o_out.last))
        else $error("high nibble word marked last or unstrobed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

// File: sim/lcd_write_checker.sv
`timescale 1ns / 1ps
module lcd_write_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  lcdws_pkg::t_in    i_req,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  lcdws_pkg::t_out   i_word,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_data,
    output int                o_fail_count,
    output int                o_outstanding
);

    localparam logic [lcdws_pkg::WAIT_W-1:0] BOOT_WAIT_US   = 14'd15000;
    localparam logic [lcdws_pkg::WAIT_W-1:0] WAKE_WAIT_US   = 14'd5000;
    localparam logic [lcdws_pkg::WAIT_W-1:0] WAKE_REPEAT_US = 14'd1000;
    localparam logic [3:0]        NIB_WAKE       = 4'h3;
    localparam logic [3:0]        NIB_FOUR_BIT   = 4'h2;
    localparam logic [7:0]        CMD_FUNC_SET   = 8'h28;
    localparam logic [7:0]        CMD_DISPLAY_ON = 8'h0C;
    localparam logic [7:0]        CMD_ENTRY_MODE = 8'h06;
    localparam logic [7:0]        ROW1_BASE      = 8'h00;
    localparam logic [7:0]        ROW2_BASE      = 8'h40;
    localparam logic [7:0]        ROW3_BASE      = 8'h10;
    localparam logic [7:0]        ROW4_BASE      = 8'h50;
    localparam int                LEADING_PLACE  = 10000;

    lcdws_pkg::t_out expected_words[$];
    int              words_seen;
    logic [7:0]      us_cycles;

    function automatic void queue_word(input logic strobe, input logic rs,
                                       input logic [3:0] nib,
                                       input logic [lcdws_pkg::WAIT_W-1:0] w);
        lcdws_pkg::t_out x;
        x.strobe_res = strobe;
        x.reg_select = rs;
        x.nibble     = nib;
        x.wait_us    = w;
        x.last       = 1'b0;
        expected_words.push_back(x);
    endfunction

    function automatic void queue_byte(input logic rs, input logic [7:0] b,
                                       input logic [lcdws_pkg::WAIT_W-1:0] w);
        queue_word(1'b1, rs, b[7:4], '0);
        queue_word(1'b1, rs, b[3:0], w);
    endfunction

    function automatic void queue_cursor(input logic [3:0] col, input logic [2:0] row);
        logic [7:0] base;
        if (row >= 3'd1 && row <= 3'd4) begin
            case (row)
                3'd1: base = ROW1_BASE;
                3'd2: base = ROW2_BASE;
                3'd3: base = ROW3_BASE;
                default: base = ROW4_BASE;
            endcase
            queue_byte(1'b0, lcdws_pkg::CMD_DDRAM + base + {4'd0, col},
                       lcdws_pkg::CMD_WAIT_US);
        end
    endfunction

    function automatic void expand_request(input lcdws_pkg::t_in r);
        int              size_prior;
        int              value;
        int              place;
        int              digit;
        logic            shown;
        logic [7:0]      ch;
        lcdws_pkg::t_out tail;
        size_prior = expected_words.size();
        case (r.action)
            lcdws_pkg::ACT_INIT: begin
                queue_word(1'b0, 1'b0, 4'h0, BOOT_WAIT_US);
                queue_word(1'b1, 1'b0, NIB_WAKE, WAKE_WAIT_US);
                queue_word(1'b1, 1'b0, NIB_WAKE, WAKE_REPEAT_US);
                queue_word(1'b1, 1'b0, NIB_WAKE, WAKE_REPEAT_US);
                queue_word(1'b1, 1'b0, NIB_FOUR_BIT, WAKE_WAIT_US);
                queue_byte(1'b0, CMD_FUNC_SET, lcdws_pkg::CMD_WAIT_US);
                queue_byte(1'b0, CMD_DISPLAY_ON, lcdws_pkg::CMD_WAIT_US);
                queue_byte(1'b0, CMD_ENTRY_MODE, lcdws_pkg::CMD_WAIT_US);
                queue_byte(1'b0, lcdws_pkg::CMD_CLEAR, lcdws_pkg::SLOW_WAIT_US);
            end
            lcdws_pkg::ACT_CMD:
                queue_byte(1'b0, r.byte_value, lcdws_pkg::CMD_WAIT_US);
            lcdws_pkg::ACT_DATA:
                queue_byte(1'b1, r.byte_value, lcdws_pkg::DATA_WAIT_US);
            lcdws_pkg::ACT_CLEAR:
                queue_byte(1'b0, lcdws_pkg::CMD_CLEAR, lcdws_pkg::SLOW_WAIT_US);
            lcdws_pkg::ACT_HOME:
                queue_byte(1'b0, lcdws_pkg::CMD_HOME, lcdws_pkg::SLOW_WAIT_US);
            lcdws_pkg::ACT_CURSOR:
                queue_cursor(r.column, r.row);
            lcdws_pkg::ACT_NUMBER: begin
                queue_cursor(r.column, r.row);
                value = r.number;
                place = LEADING_PLACE;
                shown = 1'b0;
                while (place > 0) begin
                    digit = value / place;
                    value = value % place;
                    if (!shown && digit == 0 && place != 1) begin
                        ch = lcdws_pkg::CHR_SPACE;
                    end else begin
                        ch = lcdws_pkg::CHR_ZERO + 8'(digit);
                        shown = 1'b1;
                    end
                    queue_byte(1'b1, ch, lcdws_pkg::DATA_WAIT_US);
                    place = place / 10;
                end
            end
            default: ;
        endcase
        if (expected_words.size() > size_prior) begin
            tail = expected_words.pop_back();
            tail.last = 1'b1;
            expected_words.push_back(tail);
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        o_fail_count++;
        $display("mismatch %s at word %0d (%0d cycles/us): got %0d, want %0d",
                 what, words_seen, us_cycles, got, want);
    endtask

    always @(posedge i_clk) begin
        lcdws_pkg::t_out want;
        if (!i_rst_n) begin
            expected_words.delete();
            us_cycles     <= lcdws_pkg::CPU_RESET;
            o_outstanding <= 0;
        end else begin
            if (i_cfg_we)
                us_cycles <= i_cfg_data;
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word", int'(i_word), 0);
                end else begin
                    want = expected_words.pop_front();
                    if (i_word.strobe_res !== want.strobe_res)
                        report_mismatch("strobe_res", i_word.strobe_res, want.strobe_res);
                    if (i_word.reg_select !== want.reg_select)
                        report_mismatch("reg_select", i_word.reg_select, want.reg_select);
                    if (i_word.nibble !== want.nibble)
                        report_mismatch("nibble", i_word.nibble, want.nibble);
                    if (i_word.wait_us !== want.wait_us)
                        report_mismatch("wait_us", i_word.wait_us, want.wait_us);
                    if (i_word.last !== want.last)
                        report_mismatch("last", i_word.last, want.last);
                end
                words_seen++;
            end
            if (i_in_valid && i_in_ready)
                expand_request(i_req);
            o_outstanding <= expected_words.size();
        end
    end

endmodule

// File: sim/tb_char_lcd_4bit_write_sequencer.sv
`timescale 1ns / 1ps
module tb_char_lcd_4bit_write_sequencer;

    localparam logic [2:0] ACT_UNUSED     = 3'd7;
    localparam int         CYCLE_LIMIT     = 4_000_000;
    localparam int         HOLD_OFF_CYCLES = 400;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            in_valid  = 1'b0;
    lcdws_pkg::t_in  req       = '0;
    logic            out_ready = 1'b0;
    logic            cfg_we    = 1'b0;
    logic [7:0]      cfg_data  = 8'd0;
    logic            in_ready;
    logic            out_valid;
    lcdws_pkg::t_out word;

    int         fail_count;
    int         outstanding;
    int         cycle_count = 0;
    int         sent_useful = 0;
    logic [7:0] us_setting  = lcdws_pkg::CPU_RESET;
    bit         tx_idle     = 1'b1;
    bit         rx_idle     = 1'b1;
    bit         hold_req    = 1'b0;

    always #5 clk = ~clk;

    char_lcd_4bit_write_sequencer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (word),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    lcd_write_checker word_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_req         (req),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_word        (word),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic lcdws_pkg::t_in make_request(input logic [2:0] act, input logic [7:0] b,
                                                    input logic [3:0] col,
                                                    input logic [2:0] row,
                                                    input logic [15:0] num);
        lcdws_pkg::t_in r;
        r.action     = act;
        r.byte_value = b;
        r.column     = col;
        r.row        = row;
        r.number     = num;
        return r;
    endfunction

    function automatic bit yields_words(input lcdws_pkg::t_in r);
        return !(r.action == ACT_UNUSED ||
                 (r.action == lcdws_pkg::ACT_CURSOR && (r.row < 3'd1 || r.row > 3'd4)));
    endfunction

    function automatic lcdws_pkg::t_in random_request();
        lcdws_pkg::t_in r;
        int             pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)       r.action = lcdws_pkg::ACT_INIT;
        else if (pick < 23) r.action = lcdws_pkg::ACT_CMD;
        else if (pick < 48) r.action = lcdws_pkg::ACT_DATA;
        else if (pick < 53) r.action = lcdws_pkg::ACT_CLEAR;
        else if (pick < 58) r.action = lcdws_pkg::ACT_HOME;
        else if (pick < 75) r.action = lcdws_pkg::ACT_CURSOR;
        else if (pick < 97) r.action = lcdws_pkg::ACT_NUMBER;
        else                r.action = ACT_UNUSED;
        r.byte_value = 8'($urandom);
        r.column     = 4'($urandom);
        r.row = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
                                             : 3'($urandom_range(1, 4));
        case ($urandom_range(0, 3))
            0:       r.number = 16'($urandom_range(0, 99));
            1:       r.number = 16'($urandom_range(0, 9999));
            default: r.number = 16'($urandom);
        endcase
        return r;
    endfunction

    task automatic send_request(input lcdws_pkg::t_in r);
        int gap;
        gap = tx_idle ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req      <= r;
        do @(posedge clk); while (!in_ready);
        if (yields_words(r))
            sent_useful++;
    endtask

    task automatic run_random(input int count);
        int goal;
        goal = sent_useful + count;
        while (sent_useful < goal)
            send_request(random_request());
    endtask

    // drop valid, wait out every expected word, then let a request with no words finish
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (lcdws_pkg::ENABLE_PULSE_US_DEF * us_setting + 16) @(posedge clk);
    endtask

    task automatic write_setting(input logic [7:0] v);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we     <= 1'b0;
        us_setting = v;
    endtask

    initial begin
        int  gap;
        bit  took;
        forever begin
            gap = rx_idle ? $urandom_range(0, 16) : 0;
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do begin
                @(posedge clk);
                took = out_valid;
                if (!took && hold_req) begin
                    out_ready <= 1'b0;
                    repeat (HOLD_OFF_CYCLES) @(posedge clk);
                    hold_req = 1'b0;
                    out_ready <= 1'b1;
                end
            end while (!took);
        end
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_request(make_request(lcdws_pkg::ACT_INIT, 8'h00, 4'd0, 3'd0, 16'd0));
        send_request(make_request(lcdws_pkg::ACT_CMD, 8'h00, 4'd15, 3'd7, 16'hFFFF));
        send_request(make_request(lcdws_pkg::ACT_CMD, 8'hFF, 4'd0, 3'd0, 16'd0));
        send_request(make_request(lcdws_pkg::ACT_DATA, 8'h00, 4'd0, 3'd0, 16'd0));
        send_request(make_request(lcdws_pkg::ACT_DATA, 8'hFF, 4'd15, 3'd7, 16'hFFFF));
        send_request(make_request(lcdws_pkg::ACT_DATA, 8'hA5, 4'd5, 3'd2, 16'h5A5A));
        send_request(make_request(lcdws_pkg::ACT_CLEAR, 8'h3C, 4'd0, 3'd0, 16'd0));
        send_request(make_request(lcdws_pkg::ACT_HOME, 8'hC3, 4'd0, 3'd0, 16'd0));
        send_request(make_request(lcdws_pkg::ACT_CURSOR, 8'h00, 4'd0, 3'd1, 16'd0));
        send_request(make_request(lcdws_pkg::ACT_CURSOR, 8'h00, 4'd15, 3'd2, 16'd0));
        send_request(make_request(lcdws_pkg::ACT_CURSOR, 8'h00, 4'd7, 3'd3, 16'd0));
        send_request(make_request(lcdws_pkg::ACT_CURSOR, 8'h00, 4'd15, 3'd4, 16'd0));
        send_request(make_request(lcdws_pkg::ACT_CURSOR, 8'h00, 4'd3, 3'd0, 16'd0));
        send_request(make_request(lcdws_pkg::ACT_CURSOR, 8'h00, 4'd3, 3'd5, 16'd0));
        send_request(make_request(lcdws_pkg::ACT_CURSOR, 8'h00, 4'd15, 3'd7, 16'd0));
        send_request(make_request(lcdws_pkg::ACT_NUMBER, 8'h00, 4'd0, 3'd1, 16'd0));
        send_request(make_request(lcdws_pkg::ACT_NUMBER, 8'h00, 4'd15, 3'd4, 16'd65535));
        send_request(make_request(lcdws_pkg::ACT_NUMBER, 8'h00, 4'd2, 3'd2, 16'd10000));
        send_request(make_request(lcdws_pkg::ACT_NUMBER, 8'h00, 4'd9, 3'd0, 16'd7));
        send_request(make_request(lcdws_pkg::ACT_NUMBER, 8'h00, 4'd1, 3'd3, 16'd1000));
        send_request(make_request(lcdws_pkg::ACT_NUMBER, 8'h00, 4'd4, 3'd6, 16'd909));
        send_request(make_request(lcdws_pkg::ACT_NUMBER, 8'h00, 4'd6, 3'd1, 16'd10));
        send_request(make_request(ACT_UNUSED, 8'hFF, 4'd15, 3'd7, 16'hFFFF));
        send_request(make_request(lcdws_pkg::ACT_INIT, 8'hFF, 4'd15, 3'd7, 16'hFFFF));

        write_setting(8'd1);
        run_random(130);

        // hold the receiver while requests pile up behind it
        tx_idle  = 1'b0;
        rx_idle  = 1'b0;
        hold_req = 1'b1;
        run_random(16);
        tx_idle = 1'b1;
        rx_idle = 1'b1;

        write_setting(8'd255);
        send_request(make_request(lcdws_pkg::ACT_DATA, 8'h5A, 4'd0, 3'd0, 16'd0));
        send_request(make_request(lcdws_pkg::ACT_CMD, 8'h3C, 4'd0, 3'd0, 16'd0));
        send_request(make_request(lcdws_pkg::ACT_NUMBER, 8'h00, 4'd3, 3'd2, 16'd4321));
        send_request(make_request(lcdws_pkg::ACT_HOME, 8'h00, 4'd0, 3'd0, 16'd0));

        write_setting(8'd3);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        run_random(60);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        run_random(100);

        write_setting(8'($urandom_range(2, 6)));
        run_random(150);

        drain();
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
